FILE: sv/bmprle8_pkg.sv
// ----------------------------------------------------------------------------
// bmprle8_pkg
// Shared types and constants of the RLE8 bitmap stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmprle8_pkg;

	// parse phase of the byte stream
	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_VALUE   = 3'd1,
		PH_ESCAPE  = 3'd2,
		PH_DELTA_X = 3'd3,
		PH_DELTA_Y = 3'd4,
		PH_LITERAL = 3'd5,
		PH_PAD     = 3'd6
	} phase_t;

	// second byte of an escape
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	// register indexes on the config channel
	localparam int          CFG_IDX_W       = 8;
	localparam int          CFG_DATA_W      = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 8'd1;

	localparam int          CFG_REG_W       = 14;
	localparam int          LINE_W          = 13;
	localparam int          PROD_W          = 2 * CFG_REG_W;

	localparam logic [CFG_REG_W-1:0] RST_LINE_STRIDE = 14'd4;
	localparam logic [CFG_REG_W-1:0] RST_LINE_COUNT  = 14'd1;

	// geometry registers handed to the decode core
	typedef struct packed {
		logic [CFG_REG_W-1:0] line_stride;
		logic [CFG_REG_W-1:0] line_count;
	} cfg_t;

endpackage

`default_nettype wire

FILE: sv/bmprle8_cfg.sv
// ----------------------------------------------------------------------------
// bmprle8_cfg
// Geometry registers and the registered buffer end (stride * lines, capped).
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle8_cfg #(
	parameter int ADDR_BITS = 26
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [bmprle8_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [bmprle8_pkg::CFG_DATA_W-1:0]  wr_data,
	output bmprle8_pkg::cfg_t                        cfg,
	output logic      [ADDR_BITS:0]                  buf_end
);
	import bmprle8_pkg::*;

	localparam int MW = (ADDR_BITS + 1 > PROD_W) ? ADDR_BITS + 1 : PROD_W;

	logic [CFG_REG_W-1:0] stride_q, count_q;
	logic [ADDR_BITS:0]   end_q;
	logic [CFG_REG_W-1:0] wr_stride, wr_count, wr_val;
	logic                 hit_stride, hit_count;
	logic [PROD_W-1:0]    prod;
	logic [MW-1:0]        prod_ext, cap, end_n;

	assign wr_val     = wr_data[CFG_REG_W-1:0];
	assign hit_stride = wr_en && (wr_index == REG_LINE_STRIDE);
	assign hit_count  = wr_en && (wr_index == REG_LINE_COUNT);
	assign wr_stride  = hit_stride ? wr_val : stride_q;
	assign wr_count   = hit_count ? wr_val : count_q;

	// end is computed from the value being written, so it is ready at once
	assign prod     = PROD_W'(wr_stride) * PROD_W'(wr_count);
	assign prod_ext = MW'(prod);
	assign cap      = MW'(1) << ADDR_BITS;
	assign end_n    = (prod_ext < cap) ? prod_ext : cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= RST_LINE_STRIDE;
			count_q  <= RST_LINE_COUNT;
			end_q    <= (ADDR_BITS + 1)'(PROD_W'(RST_LINE_STRIDE) * PROD_W'(RST_LINE_COUNT));
		end else begin
			if (hit_stride) begin
				stride_q <= wr_val;
			end
			if (hit_count) begin
				count_q <= wr_val;
			end
			if (hit_stride || hit_count) begin
				end_q <= end_n[ADDR_BITS:0];
			end
		end
	end

	assign cfg.line_stride = stride_q;
	assign cfg.line_count  = count_q;
	assign buf_end         = end_q;

endmodule

`default_nettype wire

FILE: sv/bmprle8_core.sv
// ----------------------------------------------------------------------------
// bmprle8_core
// Input register, per-byte parse step and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle8_core #(
	parameter int ADDR_BITS = 26
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  bmprle8_pkg::cfg_t           cfg,
	input  wire logic [ADDR_BITS:0]     buf_end,
	// byte side
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   in_sof,
	input  wire logic                   in_fin,
	// segment side
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [ADDR_BITS-1:0]        out_addr,
	output logic [7:0]                  out_len,
	output logic [7:0]                  out_val,
	output logic                        out_last
);
	import bmprle8_pkg::*;

	localparam int DW = ADDR_BITS + 1;
	localparam int CW = ((ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W) + 2;

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       sof_s1, fin_s1;

	// decode state
	phase_t              phase_q;
	logic [7:0]          pend_q;
	logic                pad_q;
	logic [DW-1:0]       dest_q;
	logic [LINE_W-1:0]   line_q;
	logic [7:0]          dx_q;
	logic                done_q;

	// result register
	logic                out_vld_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]          len_q, val_q;
	logic                last_q;

	logic step;

	// effective state after an optional restart
	phase_t              ph;
	logic [7:0]          pend;
	logic                pad;
	logic [DW-1:0]       dest;
	logic [LINE_W-1:0]   line;
	logic [7:0]          dx;
	logic                done;

	phase_t              n_ph;
	logic [7:0]          n_pend;
	logic                n_pad;
	logic [CW-1:0]       n_dest_c;
	logic [LINE_W-1:0]   n_line;
	logic [7:0]          n_dx;
	logic                n_done;
	logic [7:0]          len, val;
	logic                ends, emit;

	logic [CW-1:0]       dest_c, end_c, room;
	logic [LINE_W:0]     line_next;
	logic [CFG_REG_W-1:0] mul_a;
	logic [PROD_W-1:0]   prod;

	assign step     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || step;

	always_comb begin
		ph   = sof_s1 ? PH_COUNT : phase_q;
		pend = sof_s1 ? 8'd0 : pend_q;
		pad  = sof_s1 ? 1'b0 : pad_q;
		dest = sof_s1 ? '0 : dest_q;
		line = sof_s1 ? '0 : line_q;
		dx   = sof_s1 ? 8'd0 : dx_q;
		done = sof_s1 ? 1'b0 : done_q;

		dest_c    = CW'(dest);
		end_c     = CW'(buf_end);
		room      = end_c - dest_c;
		line_next = {1'b0, line} + (LINE_W + 1)'(1);
		// one multiplier: next line number for end of line, dy for delta
		mul_a     = (ph == PH_ESCAPE) ? CFG_REG_W'(line_next) : CFG_REG_W'(byte_s1);
		prod      = PROD_W'(mul_a) * PROD_W'(cfg.line_stride);

		n_ph     = ph;
		n_pend   = pend;
		n_pad    = pad;
		n_dest_c = dest_c;
		n_line   = line;
		n_dx     = dx;
		n_done   = done;
		len      = 8'd0;
		val      = 8'd0;
		ends     = 1'b0;

		if (!done) begin
			if (dest_c >= end_c) begin
				ends = 1'b1;
			end else begin
				unique case (ph)
					PH_COUNT: begin
						if (byte_s1 == 8'd0) begin
							n_ph = PH_ESCAPE;
						end else begin
							n_pend = byte_s1;
							n_ph   = PH_VALUE;
						end
					end
					PH_VALUE: begin
						// clip the run at the buffer end
						len      = (CW'(pend) < room) ? pend : room[7:0];
						val      = byte_s1;
						n_dest_c = dest_c + CW'(len);
						n_pend   = 8'd0;
						n_ph     = PH_COUNT;
					end
					PH_ESCAPE: begin
						n_ph = PH_COUNT;
						if (byte_s1 == ESC_EOL) begin
							if ((line_next >= (LINE_W + 1)'(cfg.line_count))
									|| line_next[LINE_W]) begin
								ends = 1'b1;
							end else begin
								n_line   = line_next[LINE_W-1:0];
								n_dest_c = CW'(prod);
							end
						end else if (byte_s1 == ESC_EOB) begin
							ends = 1'b1;
						end else if (byte_s1 == ESC_DELTA) begin
							n_ph = PH_DELTA_X;
						end else begin
							n_pend = byte_s1;
							n_pad  = byte_s1[0];
							n_ph   = PH_LITERAL;
						end
					end
					PH_DELTA_X: begin
						n_dx = byte_s1;
						n_ph = PH_DELTA_Y;
					end
					PH_DELTA_Y: begin
						// line counter stays put on delta
						n_dest_c = dest_c + CW'(dx) + CW'(prod);
						n_dx     = 8'd0;
						n_ph     = PH_COUNT;
					end
					PH_LITERAL: begin
						len      = 8'd1;
						val      = byte_s1;
						n_dest_c = dest_c + CW'(1);
						n_pend   = pend - 8'd1;
						if (pend == 8'd1) begin
							n_ph  = pad ? PH_PAD : PH_COUNT;
							n_pad = 1'b0;
						end
					end
					PH_PAD: begin
						n_ph = PH_COUNT;
					end
					default: begin
						n_ph = PH_COUNT;
					end
				endcase
				if (n_dest_c >= end_c) begin
					ends = 1'b1;
				end
			end
			if (fin_s1) begin
				ends = 1'b1;
			end
			if (ends) begin
				n_done = 1'b1;
				if (n_dest_c > end_c) begin
					n_dest_c = end_c;
				end
			end
		end
		emit = !done && (ends || (len != 8'd0));
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			sof_s1  <= in_sof;
			fin_s1  <= in_fin;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pend_q  <= 8'd0;
			pad_q   <= 1'b0;
			dest_q  <= '0;
			line_q  <= '0;
			dx_q    <= 8'd0;
			done_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_ph;
			pend_q  <= n_pend;
			pad_q   <= n_pad;
			dest_q  <= n_dest_c[DW-1:0];
			line_q  <= n_line;
			dx_q    <= n_dx;
			done_q  <= n_done;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step) begin
			out_vld_q <= emit;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			addr_q <= dest[ADDR_BITS-1:0];
			len_q  <= len;
			val_q  <= val;
			last_q <= ends;
		end
	end

	assign out_valid = out_vld_q;
	assign out_addr  = addr_q;
	assign out_len   = len_q;
	assign out_val   = val_q;
	assign out_last  = last_q;

	// an empty segment is only ever sent to report the end
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((len_q != 8'd0) || last_q))
		else $error("empty segment without finished");

	// pad flag lives only while a literal run is open
	a_pad_in_literal: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> (phase_q == PH_LITERAL))
		else $error("pad flag outside literal run");

	// a literal run in progress always has bytes left
	a_literal_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) |-> (pend_q != 8'd0))
		else $error("literal run with zero count");

	// once done, only a restart reopens decoding
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_q && !sof_s1) |=> done_q)
		else $error("decode_done cleared without start_of_image");

	// after done, bytes produce no segment
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_q && !sof_s1) |=> !out_vld_q)
		else $error("segment emitted after decoding ended");

endmodule

`default_nettype wire

FILE: sv/bmp_rle8_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_top
// RLE8 bitmap stream decoder: compressed bytes in, write segments out.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one compressed byte per transfer. s_tuser = start_of_image
//    (restarts the parse at address zero with this byte), s_tlast = final_byte.
//  m_* channel: one write segment per transfer (start address, length, value).
//    m_tlast = finished: decoding ended on this byte (end of bitmap, buffer
//    full, line count exceeded, or final byte). A segment with length zero
//    only occurs together with finished.
//  cfg_* channel: register writes, always ready. Index 0 = line_stride,
//    index 1 = line_count; other indexes are ignored. Write only while idle.
//    The buffer end (stride * lines, capped at 2^ADDR_BITS) is registered on
//    the write itself.
//  Throughput: one byte per clock while m_tready keeps up. A byte is held
//    in the input register, then parsed into the result register, which
//    offers its segment on m_tvalid. The whole step is one pass through the
//    parse logic with one stride multiplier (end-of-line and delta share it).
//  Bytes that yield no segment (counts, escapes, pads) are absorbed.
//  Reset: parse state, address and line counter clear; registers return to
//    stride 4, one line. No output is pending after reset.
//  Stall: while m_tready is low the segment holds; one more byte can sit in
//    the input register, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle8_decoder_top #(
	parameter int ADDR_BITS = 26
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	// compressed byte stream
	input  wire logic                                          s_tvalid,
	output logic                                               s_tready,
	input  wire logic [7:0]                                    s_tdata,  // [7:0] data_byte
	input  wire logic                                          s_tuser,  // start_of_image
	input  wire logic                                          s_tlast,  // final_byte
	// write segments
	output logic                                               m_tvalid,
	input  wire logic                                          m_tready,
	// low up: write_address, run_length, pixel_value, zero fill
	output logic [((ADDR_BITS + 16 + 7) / 8) * 8 - 1:0]        m_tdata,
	output logic                                               m_tlast,  // finished
	// register writes
	input  wire logic                                          cfg_valid,
	output logic                                               cfg_ready,
	input  wire logic [bmprle8_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  wire logic [bmprle8_pkg::CFG_DATA_W-1:0]            cfg_data
);
	import bmprle8_pkg::*;

	localparam int TDW = ((ADDR_BITS + 16 + 7) / 8) * 8;

	cfg_t                 cfg;
	logic [ADDR_BITS:0]   buf_end;
	logic [ADDR_BITS-1:0] seg_addr;
	logic [7:0]           seg_len, seg_val;

	assign cfg_ready = 1'b1;

	bmprle8_cfg #(
		.ADDR_BITS (ADDR_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.buf_end  (buf_end)
	);

	bmprle8_core #(
		.ADDR_BITS (ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.buf_end   (buf_end),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_sof    (s_tuser),
		.in_fin    (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (seg_addr),
		.out_len   (seg_len),
		.out_val   (seg_val),
		.out_last  (m_tlast)
	);

	// pack segment fields, address in the low bits
	assign m_tdata = TDW'({seg_val, seg_len, seg_addr});

endmodule

`default_nettype wire

FILE: test/rle8_write_tracker_pkg.sv
// ----------------------------------------------------------------------------
// rle8_write_tracker_pkg
// Tracks the decoder state of an RLE8 byte stream and the write segments
// still due from the block; checks each segment the block delivers.
// ----------------------------------------------------------------------------
package rle8_write_tracker_pkg;

	import bmprle8_pkg::*;

	localparam int ADDR_BITS = 26;
	localparam int SEG_W     = ((ADDR_BITS + 16 + 7) / 8) * 8;

	localparam logic [7:0]  CODE_ESCAPE = 8'd0;                 // lead byte of every escape
	localparam int unsigned LINE_MAX    = (1 << LINE_W) - 1;    // highest line counter value

	typedef struct {
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]           len;
		logic [7:0]           pix;
		bit                   fin;
	} segment_t;

	class rle8_write_tracker;
		segment_t             segs_due[$];
		logic [CFG_REG_W-1:0] stride;
		logic [CFG_REG_W-1:0] lines;
		phase_t               phase;
		logic [7:0]           run_left;
		bit                   pad_due;
		longint unsigned      dest;
		int unsigned          line_no;
		logic [7:0]           dx;
		bit                   done;
		int                   errors;
		int                   n_segs;
		int                   n_ends;

		function new();
			stride = RST_LINE_STRIDE;
			lines  = RST_LINE_COUNT;
			errors = 0;
			n_segs = 0;
			n_ends = 0;
			restart();
		endfunction

		function void restart();
			phase    = PH_COUNT;
			run_left = '0;
			pad_due  = 1'b0;
			dest     = 0;
			line_no  = 0;
			dx       = '0;
			done     = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_LINE_STRIDE)
				stride = data[CFG_REG_W-1:0];
			else if (idx == REG_LINE_COUNT)
				lines = data[CFG_REG_W-1:0];
		endfunction

		// Parse one accepted byte; returns 0 when the decoder ignores it.
		function bit decode_byte(logic [7:0] b, bit sof, bit fin);
			longint unsigned buf_end;
			longint unsigned room;
			longint unsigned at;
			logic [7:0]      len;
			logic [7:0]      pix;
			bit              ends;
			int unsigned     nxt;
			len  = '0;
			pix  = '0;
			ends = 1'b0;
			if (sof)
				restart();
			if (done)
				return 1'b0;
			buf_end = 64'(stride) * 64'(lines);
			if (buf_end > (64'd1 << ADDR_BITS))
				buf_end = 64'd1 << ADDR_BITS;
			at = dest;
			if (dest >= buf_end) begin
				ends = 1'b1;
			end else begin
				case (phase)
				PH_COUNT: begin
					if (b == CODE_ESCAPE) begin
						phase = PH_ESCAPE;
					end else begin
						run_left = b;
						phase    = PH_VALUE;
					end
				end
				PH_VALUE: begin
					// encoded run, clipped at the buffer end
					room     = buf_end - dest;
					len      = (64'(run_left) < room) ? run_left : 8'(room);
					pix      = b;
					dest     = dest + 64'(len);
					run_left = '0;
					phase    = PH_COUNT;
				end
				PH_ESCAPE: begin
					if (b == ESC_EOL) begin
						nxt = line_no + 1;
						if (nxt >= 32'(lines) || nxt > LINE_MAX) begin
							ends = 1'b1;
						end else begin
							line_no = nxt;
							dest    = 64'(nxt) * 64'(stride);
						end
						phase = PH_COUNT;
					end else if (b == ESC_EOB) begin
						ends  = 1'b1;
						phase = PH_COUNT;
					end else if (b == ESC_DELTA) begin
						phase = PH_DELTA_X;
					end else begin
						run_left = b;
						pad_due  = b[0];
						phase    = PH_LITERAL;
					end
				end
				PH_DELTA_X: begin
					dx    = b;
					phase = PH_DELTA_Y;
				end
				PH_DELTA_Y: begin
					// line counter stays put on a delta
					dest  = dest + 64'(dx) + 64'(b) * 64'(stride);
					dx    = '0;
					phase = PH_COUNT;
				end
				PH_LITERAL: begin
					len      = 8'd1;
					pix      = b;
					dest     = dest + 1;
					run_left = run_left - 8'd1;
					if (run_left == 0) begin
						phase   = pad_due ? PH_PAD : PH_COUNT;
						pad_due = 1'b0;
					end
				end
				default: phase = PH_COUNT;
				endcase
				if (dest >= buf_end)
					ends = 1'b1;
			end
			if (fin)
				ends = 1'b1;
			if (ends) begin
				done = 1'b1;
				if (dest > buf_end)
					dest = buf_end;
			end
			if (ends || len != 0)
				segs_due.push_back('{at[ADDR_BITS-1:0], len, pix, ends});
			return 1'b1;
		endfunction

		function void compare(string what, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			end
		endfunction

		function void match_segment(logic [SEG_W-1:0] data, bit last);
			segment_t want;
			n_segs++;
			if (last)
				n_ends++;
			if (segs_due.size() == 0) begin
				errors++;
				$display("%0t: segment with none expected, expected nothing, actual addr %0h len %0d value %0h finished %0d",
					$time, data[ADDR_BITS-1:0], data[ADDR_BITS+7:ADDR_BITS],
					data[ADDR_BITS+15:ADDR_BITS+8], last);
				return;
			end
			want = segs_due.pop_front();
			compare("write_address", 64'(want.addr), 64'(data[ADDR_BITS-1:0]));
			compare("run_length", 64'(want.len), 64'(data[ADDR_BITS+7:ADDR_BITS]));
			compare("pixel_value", 64'(want.pix), 64'(data[ADDR_BITS+15:ADDR_BITS+8]));
			compare("finished", 64'(want.fin), 64'(last));
			compare("zero fill", 64'd0, 64'(data[SEG_W-1:ADDR_BITS+16]));
		endfunction
	endclass

endpackage

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the RLE8 bitmap decoder: well-formed images with random
// runs, absolute runs, deltas and line ends, plus broken codes and noise,
// over a range of buffer geometries. Every write segment is checked against
// a state tracker fed from the accepted input bytes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmprle8_pkg::*;
	import rle8_write_tracker_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on any channel
	localparam int SETTLE_CYCLES  = 6;      // covers a byte still in the parse stage
	localparam int RANDOM_ITEMS   = 1050;   // accepted bytes in the random part

	typedef struct {
		logic [7:0] b;
		bit         sof;
		bit         fin;
	} comp_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;    // [7:0] data_byte
	logic                  s_tuser = 1'b0;  // start_of_image
	logic                  s_tlast = 1'b0;  // final_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [SEG_W-1:0]      m_tdata;         // low up: write_address, run_length, pixel_value, zero fill
	logic                  m_tlast;         // finished
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rle8_write_tracker trk = new();

	comp_byte_t byte_q[$];       // compressed bytes waiting to go out
	bit         sof_next = 1'b0; // start_of_image on the next byte queued
	int         tx_gap_max = 0;  // 0: sender never idles
	int         burst_left = 0;
	int         rx_stall_max = 0; // 0: receiver never stalls
	int         rx_left = 0;
	int         quiet = 0;
	int         n_in = 0;
	int         n_used = 0;
	int         n_cfg = 0;

	bmp_rle8_decoder_top #(
		.ADDR_BITS(ADDR_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: ready windows of random length alternating with stalls bounded
	// by rx_stall_max; always ready when rx_stall_max is zero.
	always @(posedge clk) begin
		if (rx_left != 0) begin
			rx_left <= rx_left - 1;
		end else if (rx_stall_max == 0) begin
			m_tready <= 1'b1;
		end else if (m_tready) begin
			m_tready <= 1'b0;
			rx_left  <= $urandom_range(rx_stall_max, 1) - 1;
		end else begin
			m_tready <= 1'b1;
			rx_left  <= $urandom_range(12, 1) - 1;
		end
	end

	// Monitor: values seen here are those from just before the edge. The
	// output is checked before the input is noted, so a segment can never
	// be matched against an expectation raised on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				trk.match_segment(m_tdata, m_tlast);
			if (s_tvalid && s_tready) begin
				n_in++;
				if (trk.decode_byte(s_tdata, s_tuser, s_tlast))
					n_used++;
			end
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				trk.write_reg(cfg_index, cfg_data);
			end
		end
	end

	// Watchdog: ends the run when no channel moves a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d segments still due",
				$time, WATCHDOG_LIMIT, trk.segs_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---- stream building --------------------------------------------------

	function automatic void put(logic [7:0] b);
		byte_q.push_back('{b, sof_next, 1'b0});
		sof_next = 1'b0;
	endfunction

	// flag the last queued byte as final_byte
	function automatic void mark_final();
		comp_byte_t last;
		last     = byte_q.pop_back();
		last.fin = 1'b1;
		byte_q.push_back(last);
	endfunction

	// one well-formed code with random content, now and then a stray byte
	function automatic void put_code();
		int         pick;
		logic [7:0] n;
		pick = $urandom_range(99);
		if (pick < 40) begin
			n = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(16, 1));
			put(n);
			put(8'($urandom));
		end else if (pick < 55) begin
			// absolute run, padded to an even count
			n = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 3)) : 8'($urandom_range(12, 3));
			put(CODE_ESCAPE);
			put(n);
			for (int k = 0; k < int'(n); k++)
				put(8'($urandom));
			if (n[0])
				put(8'($urandom));
		end else if (pick < 70) begin
			put(CODE_ESCAPE);
			put(ESC_EOL);
		end else if (pick < 85) begin
			put(CODE_ESCAPE);
			put(ESC_DELTA);
			put(8'($urandom));
			put(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(2)));
		end else if (pick < 90) begin
			put(CODE_ESCAPE);
			put(ESC_EOB);
		end else begin
			put(8'($urandom));
		end
	endfunction

	// an image: a handful of codes, closed by end of bitmap, a final byte,
	// or left open for the buffer end or the next image to cut it off
	function automatic void put_image(bit restart);
		sof_next = restart;
		repeat ($urandom_range(20, 2))
			put_code();
		case ($urandom_range(3))
		0: begin
			put(CODE_ESCAPE);
			put(ESC_EOB);
		end
		1: mark_final();
		default: ;
		endcase
	endfunction

	// a code cut off by final_byte
	function automatic void put_broken();
		sof_next = 1'($urandom_range(1));
		case ($urandom_range(3))
		0: put(8'($urandom_range(255, 1)));
		1: begin
			put(CODE_ESCAPE);
			put(ESC_DELTA);
			put(8'($urandom));
		end
		2: begin
			put(CODE_ESCAPE);
			put(8'($urandom_range(40, 3)));
			put(8'($urandom));
		end
		default: put(CODE_ESCAPE);
		endcase
		mark_final();
	endfunction

	function automatic void put_noise();
		repeat ($urandom_range(20, 5))
			byte_q.push_back('{8'($urandom), ($urandom_range(7) == 0), ($urandom_range(15) == 0)});
	endfunction

	// ---- drivers ------------------------------------------------------------

	// One byte transfer. valid stays high into the next byte unless the
	// burst runs out, so it never gets two assignments in one step.
	task automatic send_byte(input logic [7:0] b, input bit sof, input bit fin);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= sof;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		if (tx_gap_max != 0) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(tx_gap_max, 1)) @(posedge clk);
				burst_left = $urandom_range(16, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_all();
		comp_byte_t item;
		while (byte_q.size() != 0) begin
			item = byte_q.pop_front();
			send_byte(item.b, item.sof, item.fin);
		end
		s_tvalid <= 1'b0;
	endtask

	// register write; the caller drops cfg_valid after its last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every due segment, then for a byte that yields none to clear
	task automatic settle();
		while (trk.segs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random phase: new geometry (extremes included), a sender and
	// receiver pace, then a few images, maybe a broken code and noise.
	task automatic random_phase(input bit first);
		int n_img;
		case ($urandom_range(7))
		0: begin
			cfg_write(REG_LINE_STRIDE, 16'd1);
			cfg_write(REG_LINE_COUNT, 16'd1);
		end
		1: begin
			// largest buffer, exactly the address space
			cfg_write(REG_LINE_STRIDE, 16'd8192);
			cfg_write(REG_LINE_COUNT, 16'd8192);
		end
		2: begin
			// zero register: address already at the buffer end
			if ($urandom_range(1))
				cfg_write(REG_LINE_STRIDE, 16'd0);
			else
				cfg_write(REG_LINE_COUNT, 16'hC000);
		end
		3: begin
			cfg_write(REG_LINE_STRIDE, 16'hFFFF);
			cfg_write(REG_LINE_COUNT, 16'($urandom_range(4, 1)));
		end
		4: cfg_write(REG_LINE_COUNT, 16'($urandom_range(12, 1)));
		default: begin
			cfg_write(REG_LINE_STRIDE, 16'($urandom_range(48, 1)));
			cfg_write(REG_LINE_COUNT, 16'($urandom_range(12, 1)));
		end
		endcase
		// unknown index, must be dropped
		if ($urandom_range(3) == 0)
			cfg_write(8'($urandom_range(255, 2)), 16'($urandom));
		cfg_close();

		tx_gap_max   = ($urandom_range(4) < 2) ? 0 : $urandom_range(8, 1);
		rx_stall_max = ($urandom_range(4) < 2) ? 0 : $urandom_range(24, 1);
		burst_left   = $urandom_range(16, 1);

		// the first image may carry on from where the last phase stopped,
		// under the new geometry
		n_img = $urandom_range(3, 1);
		for (int i = 0; i < n_img; i++)
			put_image(first || i > 0 || $urandom_range(3) != 0);
		if ($urandom_range(4) == 0)
			put_broken();
		if ($urandom_range(5) == 0)
			put_noise();
		send_all();
		settle();
	endtask

	// ---- main sequence ----------------------------------------------------

	initial begin
		int used_mark;
		int n_phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 8 bytes per line, 4 lines (buffer end 32).
		cfg_write(REG_LINE_STRIDE, 16'd8);
		cfg_write(REG_LINE_COUNT, 16'd4);
		cfg_close();
		sof_next = 1'b1;
		put(8'd3); put(8'd7);                                               // encoded run
		put(CODE_ESCAPE); put(8'd3); put(8'hAA); put(8'h55); put(8'hFF);    // odd absolute run
		put(8'h00);                                                         // its pad byte
		put(CODE_ESCAPE); put(8'd4);
		put(8'h11); put(8'h22); put(8'h33); put(8'h44);                     // even absolute run
		put(CODE_ESCAPE); put(ESC_DELTA); put(8'd1); put(8'd1);             // delta
		put(CODE_ESCAPE); put(ESC_EOL);                                     // end of line
		put(8'd255); put(8'h80);                                            // run clipped at end
		put(8'h42);                                                         // ignored, done
		sof_next = 1'b1;
		put(CODE_ESCAPE); put(ESC_EOB);                                     // end of bitmap
		sof_next = 1'b1;
		put(8'd5); mark_final();                                            // final mid-code
		send_all();
		settle();

		// Line counter limit: six lines of one byte; the sixth line end
		// runs past line_count before the address reaches the buffer end.
		cfg_write(REG_LINE_STRIDE, 16'd1);
		cfg_write(REG_LINE_COUNT, 16'd6);
		cfg_close();
		sof_next = 1'b1;
		repeat (6) begin
			put(CODE_ESCAPE);
			put(ESC_EOL);
		end
		send_all();
		settle();

		// Random part, counted in accepted bytes.
		used_mark = n_in;
		n_phase   = 0;
		while (n_in - used_mark < RANDOM_ITEMS) begin
			random_phase(n_phase == 0);
			n_phase++;
		end
		settle();

		$display("Streamed %0d compressed bytes (%0d parsed) in %0d random phases, %0d register writes.",
			n_in, n_used, n_phase, n_cfg);
		$display("Checked %0d write segments, %0d of them closing a decode.", trk.n_segs, trk.n_ends);
		if (trk.errors == 0 && trk.segs_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (trk.segs_due.size() != 0)
				$display("%0t: %0d segments never delivered", $time, trk.segs_due.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
